>>> rtl/core/aalu_pkg.sv
`default_nettype none
package aalu_pkg;

    localparam int DATA_W   = 32;
    localparam int ACTION_W = 3;
    localparam int USER_W   = 4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_POW = 3'd4,
        ACT_MOD = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_POW,
        ST_POW_WAIT,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

>>> rtl/core/accumulator_alu.sv
// channel | ports  | tdata (low bit up)              | tuser (low bit up)
// input   | s_*    | first_operand, second_operand   | action, use_accumulator
// result  | m_*    | result                          | error
//
// Add, subtract, the unused codes and refused divides: accept leads to ST_DONE,
// then the result register; no new item is taken until back in ST_IDLE.
// Multiply, divide, modulo: ST_MUL or ST_DIV, one bit per cycle
// in the shift-add multiplier or the restoring divider, then ST_DONE.
// Power: one ST_POW, ST_POW_WAIT round per exponent bit up to its highest set
// bit, in two shift-add multipliers running side by side.
// Reset clears the accumulator and empties the result register.
// An item may be accepted while the previous result waits on m_tready.
`default_nettype none
module accumulator_alu
    import aalu_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [2*DATA_W-1:0]     s_tdata,  // first_operand, second_operand
    input  wire logic [USER_W-1:0]       s_tuser,  // action, use_accumulator
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic      [DATA_W-1:0]       m_tdata,  // result
    output logic      [0:0]              m_tuser   // error
);

    state_t            state_reg, state_next;
    action_t           act_reg, act_next;
    action_t           in_act;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic              err_reg, err_next;
    logic [DATA_W-1:0] pacc_reg, pacc_next;
    logic [DATA_W-1:0] psq_reg, psq_next;
    logic [DATA_W-2:0] pexp_reg, pexp_next;
    logic              mval_reg, mval_next;
    logic [DATA_W-1:0] mdata_reg, mdata_next;
    logic              merr_reg, merr_next;

    logic [DATA_W-1:0] op_a, op_b;
    logic              mul_start, div_start;
    logic [DATA_W-1:0] mul0_a, mul0_b;
    logic              mul0_done, mul1_done;
    logic [DATA_W-1:0] mul0_p, mul1_p;
    logic              div_done;
    logic [DATA_W-1:0] div_q, div_r;

    assign in_act = action_t'(s_tuser[ACTION_W-1:0]);
    assign op_a   = s_tuser[ACTION_W] ? acc_reg : s_tdata[DATA_W-1:0];
    assign op_b   = s_tdata[2*DATA_W-1:DATA_W];

    aalu_mul #(.WIDTH(DATA_W)) u_mul0 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mul0_a),
        .mplier  (mul0_b),
        .done    (mul0_done),
        .product (mul0_p)
    );

    aalu_mul #(.WIDTH(DATA_W)) u_mul1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (psq_reg),
        .mplier  (psq_reg),
        .done    (mul1_done),
        .product (mul1_p)
    );

    aalu_div #(.WIDTH(DATA_W)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (op_a),
        .divisor   (op_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb begin
        state_next = state_reg;
        act_next   = act_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        err_next   = err_reg;
        pacc_next  = pacc_reg;
        psq_next   = psq_reg;
        pexp_next  = pexp_reg;
        mval_next  = mval_reg && !m_tready;
        mdata_next = mdata_reg;
        merr_next  = merr_reg;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        mul0_a     = pacc_reg;
        mul0_b     = psq_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    act_next = in_act;
                    err_next = 1'b0;
                    case (in_act)
                        ACT_ADD: begin
                            res_next   = op_a + op_b;
                            state_next = ST_DONE;
                        end
                        ACT_SUB: begin
                            res_next   = op_a - op_b;
                            state_next = ST_DONE;
                        end
                        ACT_MUL: begin
                            mul0_a     = op_a;
                            mul0_b     = op_b;
                            mul_start  = 1'b1;
                            state_next = ST_MUL;
                        end
                        ACT_DIV, ACT_MOD: begin
                            if (op_b == '0) begin
                                res_next   = acc_reg;
                                err_next   = 1'b1;
                                state_next = ST_DONE;
                            end else begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        end
                        ACT_POW: begin
                            if (op_b[DATA_W-1]) begin
                                res_next   = DATA_W'(1);
                                state_next = ST_DONE;
                            end else begin
                                pacc_next  = DATA_W'(1);
                                psq_next   = op_a;
                                pexp_next  = op_b[DATA_W-2:0];
                                state_next = ST_POW;
                            end
                        end
                        default: begin
                            res_next   = acc_reg;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                if (mul0_done) begin
                    res_next   = mul0_p;
                    state_next = ST_DONE;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    res_next   = (act_reg == ACT_MOD) ? div_r : div_q;
                    state_next = ST_DONE;
                end
            end
            ST_POW: begin
                if (pexp_reg == '0) begin
                    res_next   = pacc_reg;
                    state_next = ST_DONE;
                end else begin
                    mul_start  = 1'b1;
                    state_next = ST_POW_WAIT;
                end
            end
            ST_POW_WAIT: begin
                if (mul0_done && mul1_done) begin
                    if (pexp_reg[0]) begin
                        pacc_next = mul0_p;
                    end
                    psq_next   = mul1_p;
                    pexp_next  = pexp_reg >> 1;
                    state_next = ST_POW;
                end
            end
            ST_DONE: begin
                // hold until the result register is free
                if (!mval_reg || m_tready) begin
                    mval_next  = 1'b1;
                    mdata_next = res_reg;
                    merr_next  = err_reg;
                    acc_next   = res_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            acc_reg   <= '0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            mval_reg  <= mval_next;
        end
        act_reg   <= act_next;
        res_reg   <= res_next;
        err_reg   <= err_next;
        pacc_reg  <= pacc_next;
        psq_reg   <= psq_next;
        pexp_reg  <= pexp_next;
        mdata_reg <= mdata_next;
        merr_reg  <= merr_next;
    end

    assign m_tvalid   = mval_reg;
    assign m_tdata    = mdata_reg;
    assign m_tuser[0] = merr_reg;

endmodule
`default_nettype wire

>>> rtl/core/aalu_mul.sv
`default_nettype none
module aalu_mul
    import aalu_pkg::*;
#(
    parameter int WIDTH = DATA_W
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] mcand,
    input  wire logic [WIDTH-1:0] mplier,
    output logic                  done,
    output logic      [WIDTH-1:0] product
);

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(WIDTH - 1);

    logic [WIDTH-1:0] mcand_reg, mcand_next;
    logic [WIDTH-1:0] mplier_reg, mplier_next;
    logic [WIDTH-1:0] prod_reg, prod_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;

    always_comb begin
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        prod_next   = prod_reg;
        cnt_next    = cnt_reg;
        run_next    = run_reg;
        done_next   = 1'b0;
        if (start) begin
            mcand_next  = mcand;
            mplier_next = mplier;
            prod_next   = '0;
            cnt_next    = '0;
            run_next    = 1'b1;
        end else if (run_reg) begin
            // one multiplier bit per cycle
            if (mplier_reg[0]) begin
                prod_next = prod_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
        cnt_reg    <= cnt_next;
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule
`default_nettype wire

>>> rtl/core/aalu_div.sv
`default_nettype none
module aalu_div
    import aalu_pkg::*;
#(
    parameter int WIDTH = DATA_W
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] dividend,
    input  wire logic [WIDTH-1:0] divisor,
    output logic                  done,
    output logic      [WIDTH-1:0] quotient,
    output logic      [WIDTH-1:0] remainder
);

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(WIDTH - 1);

    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_q_reg, neg_q_next;
    logic             neg_r_reg, neg_r_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;

    assign shifted = {rem_reg, quo_reg[WIDTH-1]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb begin
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        cnt_next   = cnt_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        if (start) begin
            // work on magnitudes, restore signs at the end
            quo_next   = dividend[WIDTH-1] ? (~dividend + WIDTH'(1)) : dividend;
            dsr_next   = divisor[WIDTH-1] ? (~divisor + WIDTH'(1)) : divisor;
            rem_next   = '0;
            cnt_next   = '0;
            neg_q_next = dividend[WIDTH-1] ^ divisor[WIDTH-1];
            neg_r_next = dividend[WIDTH-1];
            run_next   = 1'b1;
        end else if (run_reg) begin
            // one quotient bit per cycle
            if (!diff[WIDTH]) begin
                rem_next = diff[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end else begin
                rem_next = shifted[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dsr_reg   <= dsr_next;
        cnt_reg   <= cnt_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

    assign done      = done_reg;
    assign quotient  = neg_q_reg ? (~quo_reg + WIDTH'(1)) : quo_reg;
    assign remainder = neg_r_reg ? (~rem_reg + WIDTH'(1)) : rem_reg;

endmodule
`default_nettype wire

>>> rtl/core/aalu_chk.sv
`default_nettype none
module aalu_chk
    import aalu_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [DATA_W-1:0]   m_tdata,
    input wire logic [0:0]          m_tuser
);

    logic [DATA_W-1:0] last_reg;

    // track the accumulator as last delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            last_reg <= m_tdata;
        end
    end

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_error_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == last_reg)
        else $error("error item changed the accumulator");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is at work");

endmodule

bind accumulator_alu aalu_chk u_aalu_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

>>> tb/sv/accumulator_alu_tb.sv
module accumulator_alu_tb;
    import aalu_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_NOP_6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_NOP_7 = 3'd7;
    localparam int N_DIRECTED  = 25;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 128;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 8000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              err;
    } acc_result_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                use_acc;
        logic [DATA_W-1:0]   first;
        logic [DATA_W-1:0]   second;
        logic                typed;
        logic [DATA_W-1:0]   value;
        logic                err;
    } calc_vector_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [2*DATA_W-1:0] s_tdata;   // first_operand, second_operand
    logic [USER_W-1:0]   s_tuser;   // action, use_accumulator
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [DATA_W-1:0]   m_tdata;   // result
    logic [0:0]          m_tuser;   // error

    logic [DATA_W-1:0] model_acc;
    acc_result_t       pending_results[$];
    acc_result_t       oldest;
    acc_result_t       predicted;
    logic              row_typed;
    acc_result_t       row_expect;

    int  sender_idle_pct;
    int  recv_stall_pct;
    bit  long_hold;
    int  hold_left;
    int  items_sent;
    int  results_seen;
    int  refusals_seen;
    int  mismatches;
    int  quiet_cycles;

    calc_vector_t directed_vectors [N_DIRECTED] = '{
        '{ACT_ADD,   1'b1, 32'h5A5A5A5A, 32'h00000000, 1'b1, 32'h00000000, 1'b0},
        '{ACT_ADD,   1'b0, 32'h7FFFFFFF, 32'h00000001, 1'b1, 32'h80000000, 1'b0},
        '{ACT_SUB,   1'b0, 32'h80000000, 32'h00000001, 1'b1, 32'h7FFFFFFF, 1'b0},
        '{ACT_MUL,   1'b0, 32'h80000000, 32'hFFFFFFFF, 1'b1, 32'h80000000, 1'b0},
        '{ACT_DIV,   1'b0, 32'h80000000, 32'hFFFFFFFF, 1'b1, 32'h80000000, 1'b0},
        '{ACT_MOD,   1'b0, 32'h80000000, 32'hFFFFFFFF, 1'b1, 32'h00000000, 1'b0},
        '{ACT_DIV,   1'b1, 32'h00000000, 32'h00000000, 1'b1, 32'h00000000, 1'b1},
        '{ACT_ADD,   1'b0, 32'hFFFFFFF9, 32'h00000000, 1'b0, 32'h00000000, 1'b0},
        '{ACT_MOD,   1'b0, 32'h00000005, 32'h00000000, 1'b1, 32'hFFFFFFF9, 1'b1},
        '{ACT_DIV,   1'b1, 32'h00000000, 32'h00000002, 1'b0, 32'h00000000, 1'b0},
        '{ACT_MOD,   1'b0, 32'hFFFFFFF9, 32'h00000002, 1'b0, 32'h00000000, 1'b0},
        '{ACT_MOD,   1'b0, 32'h00000007, 32'hFFFFFFFE, 1'b0, 32'h00000000, 1'b0},
        '{ACT_POW,   1'b0, 32'h00000003, 32'hFFFFFFFF, 1'b1, 32'h00000001, 1'b0},
        '{ACT_POW,   1'b0, 32'h00000002, 32'd31,       1'b1, 32'h80000000, 1'b0},
        '{ACT_POW,   1'b0, 32'h00000002, 32'd32,       1'b1, 32'h00000000, 1'b0},
        '{ACT_POW,   1'b0, 32'h00000003, 32'h7FFFFFFF, 1'b0, 32'h00000000, 1'b0},
        '{ACT_POW,   1'b1, 32'h00000000, 32'h00000000, 1'b1, 32'h00000001, 1'b0},
        '{ACT_NOP_6, 1'b1, 32'h00000000, 32'h12345678, 1'b1, 32'h00000001, 1'b0},
        '{ACT_NOP_7, 1'b0, 32'hFFFFFFFF, 32'h00000000, 1'b1, 32'h00000001, 1'b0},
        '{ACT_MUL,   1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'h00000001, 1'b0},
        '{ACT_SUB,   1'b1, 32'h00000000, 32'h80000000, 1'b0, 32'h00000000, 1'b0},
        '{ACT_DIV,   1'b0, 32'h7FFFFFFF, 32'h80000000, 1'b0, 32'h00000000, 1'b0},
        '{ACT_DIV,   1'b0, 32'h80000000, 32'h80000000, 1'b0, 32'h00000000, 1'b0},
        '{ACT_MOD,   1'b1, 32'h00000000, 32'h80000000, 1'b0, 32'h00000000, 1'b0},
        '{ACT_ADD,   1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFE, 1'b0}
    };

    int sender_pcts [4] = '{0, 56, 0, 27};
    int recv_pcts   [4] = '{0, 0, 56, 27};

    accumulator_alu i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic acc_result_t next_accumulator(
        input logic [ACTION_W-1:0] action,
        input logic                use_acc,
        input logic [DATA_W-1:0]   first,
        input logic [DATA_W-1:0]   second,
        input logic [DATA_W-1:0]   acc_now
    );
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] mag_l;
        logic [DATA_W-1:0] mag_r;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] prod;
        logic [DATA_W-1:0] expo;
        acc_result_t       r;
        lhs     = use_acc ? acc_now : first;
        r.value = acc_now;
        r.err   = 1'b0;
        mag_l   = lhs[DATA_W-1] ? -lhs : lhs;
        mag_r   = second[DATA_W-1] ? -second : second;
        case (action)
            ACT_ADD: r.value = lhs + second;
            ACT_SUB: r.value = lhs - second;
            ACT_MUL: r.value = lhs * second;
            ACT_DIV, ACT_MOD: begin
                if (second == '0) begin
                    r.err = 1'b1;
                end else begin
                    quo = mag_l / mag_r;
                    rem = mag_l % mag_r;
                    if (action == ACT_DIV)
                        r.value = (lhs[DATA_W-1] ^ second[DATA_W-1]) ? -quo : quo;
                    else
                        r.value = lhs[DATA_W-1] ? -rem : rem;
                end
            end
            ACT_POW: begin
                if (second[DATA_W-1]) begin
                    r.value = DATA_W'(1);
                end else begin
                    prod = DATA_W'(1);
                    base = lhs;
                    expo = second;
                    while (expo != '0) begin
                        if (expo[0])
                            prod = prod * base;
                        base = base * base;
                        expo = expo >> 1;
                    end
                    r.value = prod;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(9))
            0: return 32'h00000000;
            1: return 32'h7FFFFFFF;
            2: return 32'h80000000;
            3: return 32'hFFFFFFFF;
            4, 5: return $urandom_range(40) - 20;
            default: return $urandom;
        endcase
    endfunction

    // compare the oldest expectation first, then record the newly accepted item
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h error %0d", m_tdata, m_tuser[0]);
                end else begin
                    oldest = pending_results.pop_front();
                    if (oldest.err)
                        refusals_seen++;
                    if (m_tdata !== oldest.value || m_tuser[0] !== oldest.err) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected %h error %0d, got %h error %0d",
                                     results_seen, oldest.value, oldest.err,
                                     m_tdata, m_tuser[0]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predicted = next_accumulator(s_tuser[ACTION_W-1:0], s_tuser[ACTION_W],
                                             s_tdata[DATA_W-1:0], s_tdata[2*DATA_W-1:DATA_W],
                                             model_acc);
                model_acc = predicted.value;
                pending_results.push_back(row_typed ? row_expect : predicted);
            end
        end else begin
            model_acc = '0;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("no handshake for %0d cycles, %0d results outstanding",
                             quiet_cycles, pending_results.size());
                    $display("accumulator_alu_tb failed");
                    $finish;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (long_hold) begin
            hold_left = HOLD_CYCLES;
            long_hold = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_item(
        input logic [ACTION_W-1:0] action,
        input logic                use_acc,
        input logic [DATA_W-1:0]   first,
        input logic [DATA_W-1:0]   second,
        input logic                typed,
        input acc_result_t         typed_result
    );
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid   <= 1'b1;
        s_tdata    <= {second, first};
        s_tuser    <= {use_acc, action};
        row_typed  <= typed;
        row_expect <= typed_result;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_random();
        logic [ACTION_W-1:0] action;
        logic [DATA_W-1:0]   second;
        int                  roll;
        if ($urandom_range(99) < 4)
            action = $urandom_range(1) ? ACT_NOP_7 : ACT_NOP_6;
        else
            action = ACTION_W'($urandom_range(5));
        second = pick_operand();
        roll = $urandom_range(99);
        if (action == ACT_DIV || action == ACT_MOD) begin
            if (roll < 12)
                second = '0;
        end else if (action == ACT_POW) begin
            if (roll < 8)
                second = $urandom | 32'h80000000;
            else if (roll < 11)
                second = $urandom & 32'h7FFFFFFF;
            else
                second = $urandom_range(24);
        end
        send_item(action, 1'($urandom_range(1)), pick_operand(), second, 1'b0, '0);
    endtask

    // drop valid and hold off until every expected result is back
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (results_seen != items_sent)
            @(posedge aclk);
    endtask

    initial begin
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        row_typed       = 1'b0;
        row_expect      = '0;
        aresetn         = 1'b0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        long_hold       = 1'b0;
        hold_left       = 0;
        items_sent      = 0;
        results_seen    = 0;
        refusals_seen   = 0;
        mismatches      = 0;
        quiet_cycles    = 0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_item(directed_vectors[i].action, directed_vectors[i].use_acc,
                      directed_vectors[i].first, directed_vectors[i].second,
                      directed_vectors[i].typed,
                      '{directed_vectors[i].value, directed_vectors[i].err});
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            sender_idle_pct = sender_pcts[p % 4];
            recv_stall_pct  = recv_pcts[p % 4];
            if (p == 0)
                long_hold = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random();
            wait_drained();
        end

        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d items driven: directed edge cases, then random items under four",
                 items_sent);
        $display("handshake idle patterns; %0d results checked, %0d by-zero refusals",
                 results_seen, refusals_seen);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("accumulator_alu_tb passed");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     mismatches, pending_results.size());
            $display("accumulator_alu_tb failed");
        end
        $finish;
    end

endmodule
